### hdl/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int unsigned BASE_WIDTH = 6;
  localparam int unsigned CHAR_WIDTH = 8;
  localparam int unsigned REG_WIDTH  = 32;

  localparam logic [BASE_WIDTH-1:0] SOURCE_BASE_RESET = 6'd10;
  localparam logic [BASE_WIDTH-1:0] TARGET_BASE_RESET = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MIN          = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX          = 6'd36;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41; // 'A'
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A; // 'Z'
  localparam logic [BASE_WIDTH-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [BASE_WIDTH-1:0] DIGIT_MAX   = 6'd35;

  // Register indexes on the configuration port
  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_INIT = 3'd1;
  localparam step_t STEP_DIV  = 3'd2;
  localparam step_t STEP_PUSH = 3'd3;
  localparam step_t STEP_READ = 3'd4;
  localparam step_t STEP_EMIT = 3'd5;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN_LAST  = 3'd1,
    COND_DIV_DONE = 3'd2,
    COND_QUO_ZERO = 3'd3,
    COND_IDX_ZERO = 3'd4
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  init;
    logic  div;
    logic  push;
    logic  emit;
    cond_e cond;
    step_t jump;
    step_t next;
  } ctrl_t;

  // Control store: when the condition holds go to jump, else to next
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{in_ready: 1'b0, init: 1'b0, div: 1'b0, push: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, jump: STEP_IDLE, next: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_IN_LAST;
        w.jump     = STEP_INIT;
        w.next     = STEP_IDLE;
      end
      STEP_INIT: begin
        w.init = 1'b1;
        w.jump = STEP_DIV;
      end
      STEP_DIV: begin
        w.div  = 1'b1;
        w.cond = COND_DIV_DONE;
        w.jump = STEP_PUSH;
        w.next = STEP_DIV;
      end
      STEP_PUSH: begin
        w.push = 1'b1;
        w.cond = COND_QUO_ZERO;
        w.jump = STEP_READ;
        w.next = STEP_DIV;
      end
      STEP_READ: begin
        w.jump = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_IDX_ZERO;
        w.jump = STEP_IDLE;
        w.next = STEP_READ;
      end
      default: begin
        w.jump = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [BASE_WIDTH-1:0] clamp_base(input logic [BASE_WIDTH-1:0] b);
    logic [BASE_WIDTH-1:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

  function automatic logic [BASE_WIDTH-1:0] char_value(input logic [CHAR_WIDTH-1:0] c);
    logic [CHAR_WIDTH-1:0] t;
    logic [BASE_WIDTH-1:0] r;
    r = '0;
    t = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      r = t[BASE_WIDTH-1:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      t = c - CHAR_UPPER_A;
      r = t[BASE_WIDTH-1:0] + DIGIT_TEN;
    end
    return r;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] value_char(input logic [BASE_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] r;
    if (d < DIGIT_TEN) begin
      r = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      r = CHAR_UPPER_A + CHAR_WIDTH'(d - DIGIT_TEN);
    end
    return r;
  endfunction

endpackage

### hdl/rsc_ram.sv
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/radix_string_converter.sv
`timescale 1ns / 1ps

// Radix string converter.
// Input channel (in_valid_i / in_stall_o, char_code_i, end_of_number_i) takes
// one ASCII digit per transaction, most significant first; end_of_number_i
// marks the last one. Output channel (out_valid_o / out_stall_i) returns the
// number in the target base as ASCII, most significant first, last_digit_o on
// the final character and rejected_o on every character of an invalid number.
// Bases are set over the APB port: source_base at 0x0, target_base at 0x4.
// Each non-final character is one multiply-accumulate step.
// After the final character the microsequencer runs a shared bit-serial
// divider once per output digit, then each digit is read from the digit
// buffer and presented. The next number is accepted after the last digit
// enters the output register.
// Reset restores source_base 10, target_base 2 and clears the accumulator.
// A stalled output holds its transaction and pauses the emit step; no input
// is taken until the last digit of the run is in the output register.
module radix_string_converter #(
  parameter int unsigned MAX_DIGITS  = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input characters
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_number_i,
  // output digits
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  digit_char_o,
  output logic        last_digit_o,
  output logic        rejected_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(VALUE_WIDTH);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BW = rsc_pkg::BASE_WIDTH;
  localparam logic [IW-1:0] BIT_LAST  = IW'(VALUE_WIDTH - 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_DIGITS);

  // configuration registers
  logic [BW-1:0] source_base_q, target_base_q;
  logic          cfg_write;
  logic          cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_base_q <= rsc_pkg::SOURCE_BASE_RESET;
      target_base_q <= rsc_pkg::TARGET_BASE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rsc_pkg::REG_SOURCE_BASE: source_base_q <= pwdata[BW-1:0];
        rsc_pkg::REG_TARGET_BASE: target_base_q <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      rsc_pkg::REG_SOURCE_BASE: prdata = {(rsc_pkg::REG_WIDTH - BW)'(0), source_base_q};
      rsc_pkg::REG_TARGET_BASE: prdata = {(rsc_pkg::REG_WIDTH - BW)'(0), target_base_q};
      default:                  prdata = '0;
    endcase
  end

  // sequencer
  rsc_pkg::step_t pc_q, pc_d;
  rsc_pkg::ctrl_t ctrl;
  logic           cond_met;
  logic           out_free;
  logic           in_accept;

  assign ctrl       = rsc_pkg::ucode_rom(pc_q);
  assign in_stall_o = !ctrl.in_ready;
  assign in_accept  = in_valid_i && ctrl.in_ready;

  // datapath state
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [CW-1:0]          cnt_q;
  logic                   inv_q;
  logic                   rej_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [BW-1:0]          rem_q;
  logic [IW-1:0]          bit_q;
  logic [IW-1:0]          ndig_q;
  logic [IW-1:0]          idx_q;

  always_comb begin
    unique case (ctrl.cond)
      rsc_pkg::COND_ALWAYS:   cond_met = 1'b1;
      rsc_pkg::COND_IN_LAST:  cond_met = in_accept && end_of_number_i;
      rsc_pkg::COND_DIV_DONE: cond_met = (bit_q == BIT_LAST);
      rsc_pkg::COND_QUO_ZERO: cond_met = (quo_q == '0);
      rsc_pkg::COND_IDX_ZERO: cond_met = (idx_q == '0);
      default:                cond_met = 1'b1;
    endcase
    if (ctrl.emit && !out_free) begin
      pc_d = pc_q;
    end else if (cond_met) begin
      pc_d = ctrl.jump;
    end else begin
      pc_d = ctrl.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= rsc_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // multiply-accumulate for one input character
  logic [BW-1:0]            src_base;
  logic [BW-1:0]            tgt_base;
  logic [BW-1:0]            digit_val;
  logic                     cnt_full;
  logic                     inv_next;
  logic [VALUE_WIDTH+BW-1:0] mac_prod;
  logic [VALUE_WIDTH-1:0]   mac_sum;

  assign src_base  = rsc_pkg::clamp_base(source_base_q);
  assign tgt_base  = rsc_pkg::clamp_base(target_base_q);
  assign digit_val = rsc_pkg::char_value(char_code_i);
  assign cnt_full  = (cnt_q == COUNT_MAX);
  assign inv_next  = inv_q || cnt_full || (digit_val >= src_base);
  assign mac_prod  = {BW'(0), acc_q} * (VALUE_WIDTH + BW)'(src_base);
  assign mac_sum   = mac_prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(digit_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      inv_q <= 1'b0;
    end else if (ctrl.init) begin
      acc_q <= '0;
      cnt_q <= '0;
      inv_q <= 1'b0;
    end else if (in_accept) begin
      if (!cnt_full) begin
        cnt_q <= cnt_q + CW'(1);
      end
      inv_q <= inv_next;
      if (!inv_next) begin
        acc_q <= mac_sum;
      end
    end
  end

  // restoring division, one quotient bit per step
  logic [BW:0]   trial;
  logic          trial_ge;
  logic [BW:0]   trial_sub;

  assign trial     = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign trial_ge  = (trial >= {1'b0, tgt_base});
  assign trial_sub = trial - {1'b0, tgt_base};

  always_ff @(posedge clk_i) begin
    if (ctrl.init) begin
      quo_q  <= inv_q ? '0 : acc_q;
      rej_q  <= inv_q;
      rem_q  <= '0;
      bit_q  <= '0;
      ndig_q <= '0;
    end else if (ctrl.div) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[BW-1:0] : trial[BW-1:0];
      bit_q <= bit_q + IW'(1);
    end else if (ctrl.push) begin
      rem_q  <= '0;
      bit_q  <= '0;
      ndig_q <= ndig_q + IW'(1);
      idx_q  <= ndig_q;
    end else if (ctrl.emit && out_free && idx_q != '0) begin
      idx_q <= idx_q - IW'(1);
    end
  end

  // digit buffer, least significant digit at address 0
  logic [BW-1:0] buf_rdata;

  rsc_ram #(
    .WIDTH (BW),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_buf (
    .clk_i   (clk_i),
    .we_i    (ctrl.push),
    .waddr_i (ndig_q),
    .wdata_i (rem_q),
    .raddr_i (idx_q),
    .rdata_o (buf_rdata)
  );

  // output register
  logic       out_valid_q;
  logic [7:0] digit_char_q;
  logic       last_digit_q;
  logic       rejected_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && out_free) begin
      digit_char_q <= rsc_pkg::value_char(buf_rdata);
      last_digit_q <= (idx_q == '0);
      rejected_q   <= rej_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_char_q;
  assign last_digit_o = last_digit_q;
  assign rejected_o   = rejected_q;

endmodule

### test/tb_radix_string_converter.sv
`timescale 1ns / 1ps

module tb_radix_string_converter;
  import rsc_pkg::*;

  localparam int unsigned MAX_DIGITS     = 32;
  localparam int unsigned VALUE_WIDTH    = 32;
  localparam int unsigned IDLE_MAX       = 19;
  localparam int unsigned ITEM_TARGET    = 450;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned HOLD_AFTER     = 1;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned WATCHDOG_LIMIT = 6000;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] code;
    logic                  last;
    logic                  rejected;
  } digit_t;

  // Tracks the converter state and the queue of digits still to come out.
  class conversion_scoreboard;
    logic [BASE_WIDTH-1:0]  src_radix;
    logic [BASE_WIDTH-1:0]  dst_radix;
    logic [VALUE_WIDTH-1:0] acc_value;
    int unsigned            char_total;
    bit                     poisoned;
    digit_t                 expected_digits[$];
    int unsigned            errors;

    function new();
      src_radix  = SOURCE_BASE_RESET;
      dst_radix  = TARGET_BASE_RESET;
      acc_value  = '0;
      char_total = 0;
      poisoned   = 1'b0;
      errors     = 0;
    endfunction

    function int unsigned effective_radix(logic [BASE_WIDTH-1:0] b);
      if (b < BASE_MIN) return BASE_MIN;
      if (b > BASE_MAX) return BASE_MAX;
      return b;
    endfunction

    function logic [CHAR_WIDTH-1:0] glyph(int unsigned d);
      if (d < DIGIT_TEN) return CHAR_ZERO + CHAR_WIDTH'(d);
      return CHAR_UPPER_A + CHAR_WIDTH'(d - DIGIT_TEN);
    endfunction

    function int unsigned digit_of(logic [CHAR_WIDTH-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A) + DIGIT_TEN;
      return 0;
    endfunction

    function int unsigned pending();
      return expected_digits.size();
    endfunction

    function void set_register(logic idx, logic [31:0] word);
      if (idx == REG_SOURCE_BASE) begin
        src_radix = word[BASE_WIDTH-1:0];
      end else if (idx == REG_TARGET_BASE) begin
        dst_radix = word[BASE_WIDTH-1:0];
      end
    endfunction

    function void note_char(logic [CHAR_WIDTH-1:0] c, logic last);
      int unsigned            sr;
      int unsigned            dr;
      int unsigned            d;
      int unsigned            n;
      int unsigned            lsd_first[VALUE_WIDTH];
      logic [VALUE_WIDTH-1:0] v;
      digit_t                 item;
      sr = effective_radix(src_radix);
      dr = effective_radix(dst_radix);
      d  = digit_of(c);
      if (char_total >= MAX_DIGITS) begin
        poisoned = 1'b1;
      end else begin
        char_total++;
      end
      if (d >= sr) poisoned = 1'b1;
      if (!poisoned) acc_value = acc_value * VALUE_WIDTH'(sr) + VALUE_WIDTH'(d);
      if (!last) return;
      // zero still yields one digit
      v = poisoned ? '0 : acc_value;
      n = 0;
      do begin
        lsd_first[n] = int'(v % VALUE_WIDTH'(dr));
        v = v / VALUE_WIDTH'(dr);
        n++;
      end while (v != 0);
      for (int k = n; k > 0; k--) begin
        item.code     = glyph(lsd_first[k-1]);
        item.last     = (k == 1);
        item.rejected = poisoned;
        expected_digits.push_back(item);
      end
      acc_value  = '0;
      char_total = 0;
      poisoned   = 1'b0;
    endfunction

    function void check_digit(logic [CHAR_WIDTH-1:0] c, logic last, logic rejected);
      digit_t want;
      bit     bad;
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit transaction, digit_char %h", $time, c);
        errors++;
        return;
      end
      want = expected_digits.pop_front();
      bad  = 1'b0;
      if (c !== want.code) begin
        $display("%0t: digit_char expected %h, actual %h", $time, want.code, c);
        bad = 1'b1;
      end
      if (last !== want.last) begin
        $display("%0t: last_digit expected %b, actual %b", $time, want.last, last);
        bad = 1'b1;
      end
      if (rejected !== want.rejected) begin
        $display("%0t: rejected expected %b, actual %b", $time, want.rejected, rejected);
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [CHAR_WIDTH-1:0] char_code_i     = '0;
  logic                  end_of_number_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [CHAR_WIDTH-1:0] digit_char_o;
  logic                  last_digit_o;
  logic                  rejected_o;
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [2:0]            paddr           = '0;
  logic [31:0]           pwdata          = '0;
  logic [31:0]           prdata;
  logic                  pready;

  conversion_scoreboard  sb;
  bit                    steady       = 1'b0;
  int unsigned           items_sent   = 0;
  int unsigned           quiet_cycles = 0;
  logic [BASE_WIDTH-1:0] src_setting  = SOURCE_BASE_RESET;

  radix_string_converter #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_number_i(end_of_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_char_o   (digit_char_o),
    .last_digit_o   (last_digit_o),
    .rejected_o     (rejected_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_gap();
    if (steady) return 0;
    return $urandom_range(0, IDLE_MAX);
  endfunction

  function automatic logic [31:0] random_base_word();
    logic [31:0] w;
    int unsigned p;
    w = $urandom();
    p = $urandom_range(0, 9);
    if (p == 0) begin
      w[BASE_WIDTH-1:0] = BASE_MIN;
    end else if (p == 1) begin
      w[BASE_WIDTH-1:0] = BASE_MAX;
    end else if (p == 2) begin
      w[BASE_WIDTH-1:0] = BASE_WIDTH'($urandom_range(0, 63));
    end else begin
      w[BASE_WIDTH-1:0] = BASE_WIDTH'($urandom_range(BASE_MIN, BASE_MAX));
    end
    return w;
  endfunction

  task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    char_code_i     <= c;
    end_of_number_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] word);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SOURCE_BASE) src_setting = word[BASE_WIDTH-1:0];
  endtask

  // Drop valid, drain every pending digit, then let the core go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] src_word, input logic [31:0] dst_word);
    settle();
    apb_write(REG_SOURCE_BASE, src_word);
    apb_write(REG_TARGET_BASE, dst_word);
  endtask

  task automatic send_number(input int unsigned len);
    int unsigned           radix;
    int unsigned           p;
    logic [CHAR_WIDTH-1:0] c;
    radix = sb.effective_radix(src_setting);
    for (int unsigned k = 0; k < len; k++) begin
      p = $urandom_range(0, 99);
      if (p < 88) begin
        c = sb.glyph($urandom_range(0, radix - 1));
      end else if (p < 93 && radix < BASE_MAX) begin
        c = sb.glyph($urandom_range(radix, DIGIT_MAX));
      end else begin
        c = CHAR_WIDTH'($urandom_range(0, 255));
      end
      send_char(c, k == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) sb.set_register(paddr[2], pwdata);
      if (in_valid_i && !in_stall_o) sb.note_char(char_code_i, end_of_number_i);
      if (out_valid_o && !out_stall_i) sb.check_digit(digit_char_o, last_digit_o, rejected_o);
      if ((psel && penable && pwrite && pready) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Digit receiver: random stall per transaction, one long hold-off early on
  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      hold = (taken == HOLD_AFTER) ? HOLD_CYCLES : idle_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    int unsigned p;
    int unsigned len;
    int unsigned numbers;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset bases: decimal in, binary out
    send_char("0", 1'b1);
    send_char("2", 1'b0);
    send_char("5", 1'b0);
    send_char("5", 1'b1);
    send_char("1", 1'b0);
    send_char("A", 1'b1);                 // digit above the source base
    send_char("1", 1'b0);
    send_char(8'h00, 1'b0);               // unknown codes count as zero
    send_char(8'hFF, 1'b1);

    // all-ones value gives the longest run of digits
    configure(32'd16, 32'd2);
    for (int k = 0; k < 8; k++) send_char("F", k == 7);

    // out-of-range register values saturate
    configure(32'd0, 32'd63);
    send_char("1", 1'b0);
    send_char("1", 1'b1);
    send_char("2", 1'b1);
    configure(32'd37, 32'd1);
    send_char("Z", 1'b1);

    // source base changes between two characters of one number
    configure(32'd16, 32'd16);
    send_char("F", 1'b0);
    settle();
    apb_write(REG_SOURCE_BASE, 32'd8);
    send_char("7", 1'b1);

    numbers = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) configure(random_base_word(), random_base_word());
      steady = ($urandom_range(0, 7) == 0);
      p = $urandom_range(0, 99);
      if (numbers == 0) begin
        len = MAX_DIGITS;
      end else if (numbers == 1) begin
        len = MAX_DIGITS + 1;
      end else if (p < 80) begin
        len = $urandom_range(1, 8);
      end else if (p < 92) begin
        len = $urandom_range(9, MAX_DIGITS - 1);
      end else begin
        len = $urandom_range(MAX_DIGITS, MAX_DIGITS + 2);
      end
      send_number(len);
      numbers++;
    end

    steady = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
